// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the false-color encoder RTL.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define VDFC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define VDFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/vdfc_pkg.sv =====
// Shared types, widths, codes and the color palette of the false-color encoder.
// No dependencies; used by every module of the block.
package vdfc_pkg;

  localparam int unsigned GRID_RES_MAX_DEF = 256;

  localparam int unsigned VI_W     = 16;
  localparam int unsigned ELEV_W   = 24;
  localparam int unsigned MAXE_W   = 23;
  localparam int unsigned GRID_W   = 9;
  localparam int unsigned LEVEL_W  = 5;
  localparam int unsigned FACE_W   = 3;
  localparam int unsigned PATCH_W  = 20;
  localparam int unsigned BC_W     = 24;
  localparam int unsigned BI_W     = 8;
  localparam int unsigned TEMP_W   = 17;
  localparam int unsigned HUM_W    = 17;
  localparam int unsigned CH_W     = 8;

  // Ramp fraction: numerator and denominator both fit below 2^22
  localparam int unsigned RAMP_W   = 22;
  // 100 * clamped elevation, and 78 * max elevation, fit below 2^30
  localparam int unsigned H_W      = 30;
  // Divider operands: 37 * max elevation fits below 2^29
  localparam int unsigned NUM_W    = 29;
  localparam int unsigned PROD_W   = NUM_W + CH_W;
  localparam int unsigned Q_W      = CH_W;

  localparam int unsigned CHK_BITS_PER_STAGE = 2;
  localparam int unsigned CHK_STAGES         = VI_W / CHK_BITS_PER_STAGE;

  // Operand stages + multiply stage + one stage per quotient bit
  localparam int unsigned PREP_STAGES = 2;
  localparam int unsigned DIV_STAGES  = 1 + Q_W;
  localparam int unsigned PIPE_LAT    = PREP_STAGES + DIV_STAGES;

  localparam logic [MAXE_W-1:0] MIN_SPAN    = MAXE_W'(16);
  localparam logic [23:0]       TEMP_OFFSET = 24'd5712640;
  localparam logic [RAMP_W-1:0] TEMP_DEN    = RAMP_W'(2560000);
  localparam logic [RAMP_W-1:0] HUM_DEN     = RAMP_W'(65536);

  typedef enum logic [2:0] {
    MODE_BIOME     = 3'd0,
    MODE_LEVEL     = 3'd1,
    MODE_FACE      = 3'd2,
    MODE_CHECKER   = 3'd3,
    MODE_ELEV      = 3'd4,
    MODE_TEMP      = 3'd5,
    MODE_HUMID     = 3'd6,
    MODE_BIOME_IDX = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    REG_COLOR_MODE  = 3'd0,
    REG_MAX_ELEV    = 3'd1,
    REG_MAX_DEPTH   = 3'd2,
    REG_GRID_RES    = 3'd3,
    REG_PATCH_LEVEL = 3'd4,
    REG_PATCH_FACE  = 3'd5,
    REG_PATCH_X     = 3'd6,
    REG_PATCH_Y     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    mode_t               mode;
    logic [MAXE_W-1:0]   max_elev;
    logic [MAXE_W-1:0]   max_depth;
    logic [GRID_W-1:0]   grid_res;
    logic [LEVEL_W-1:0]  level;
    logic [FACE_W-1:0]   face;
    logic [PATCH_W-1:0]  px;
    logic [PATCH_W-1:0]  py;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgb_t;

  // One color channel: base +/- floor-or-ceil(k * num / den)
  typedef struct packed {
    logic [CH_W-1:0]  base;
    logic             neg;
    logic [CH_W-1:0]  k;
    logic [NUM_W-1:0] num;
  } chan_op_t;

  typedef struct packed {
    logic [CH_W-1:0] base;
    logic            neg;
    logic [Q_W-1:0]  q;
    logic            rem_nz;
  } div_res_t;

  function automatic rgb_t palette(input logic [2:0] idx);
    rgb_t c;
    case (idx)
      3'd0:    c = '{r: 8'd220, g: 8'd60,  b: 8'd60};
      3'd1:    c = '{r: 8'd60,  g: 8'd200, b: 8'd90};
      3'd2:    c = '{r: 8'd70,  g: 8'd110, b: 8'd230};
      3'd3:    c = '{r: 8'd230, g: 8'd190, b: 8'd60};
      3'd4:    c = '{r: 8'd200, g: 8'd90,  b: 8'd220};
      3'd5:    c = '{r: 8'd70,  g: 8'd210, b: 8'd210};
      3'd6:    c = '{r: 8'd240, g: 8'd140, b: 8'd60};
      default: c = '{r: 8'd170, g: 8'd170, b: 8'd170};
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/vdfc_prep.sv =====
// Operand preparation: two register stages that turn a vertex and the mode
// into per-channel divider operands. Depends on vdfc_pkg.
module vdfc_prep import vdfc_pkg::*; (
  input  logic                     clk,
  input  logic                     pipe_en,
  input  cfg_t                     cfg,
  input  logic signed [ELEV_W-1:0] elevation,
  input  logic [BC_W-1:0]          biome_color,
  input  logic [BI_W-1:0]          biome_index,
  input  logic [TEMP_W-1:0]        temperature,
  input  logic [HUM_W-1:0]         humidity,
  output chan_op_t [2:0]           ops,
  output logic [NUM_W-1:0]         den
);

  // Spans clamped to at least one metre
  logic [MAXE_W-1:0] m_eff;
  logic [MAXE_W-1:0] d_eff;
  assign m_eff = (cfg.max_elev  < MIN_SPAN) ? MIN_SPAN : cfg.max_elev;
  assign d_eff = (cfg.max_depth < MIN_SPAN) ? MIN_SPAN : cfg.max_depth;

  // ---------------- stage 1: clamp elevation, build ramp fraction
  logic [ELEV_W-1:0]  mag_neg;
  logic [MAXE_W-1:0]  n_neg_nxt;
  logic [MAXE_W-1:0]  n_pos;
  logic [H_W-1:0]     h100_nxt;
  logic [23:0]        temp100;
  logic [23:0]        temp_diff;
  logic [RAMP_W-1:0]  t_num;
  logic [RAMP_W-1:0]  h_num;
  logic [RAMP_W-1:0]  rnum_nxt;
  logic [RAMP_W-1:0]  rden_nxt;

  always_comb begin
    mag_neg   = ELEV_W'(-elevation);
    n_neg_nxt = (mag_neg > {1'b0, d_eff}) ? d_eff : mag_neg[MAXE_W-1:0];
    n_pos     = (elevation[MAXE_W-1:0] > m_eff) ? m_eff : elevation[MAXE_W-1:0];
    h100_nxt  = H_W'(n_pos) * H_W'(100);

    temp100   = 24'(temperature) * 24'd100;
    temp_diff = temp100 - TEMP_OFFSET;
    if (temp100 < TEMP_OFFSET) begin
      t_num = '0;
    end else if (temp_diff > 24'(TEMP_DEN)) begin
      t_num = TEMP_DEN;
    end else begin
      t_num = temp_diff[RAMP_W-1:0];
    end
    h_num = (humidity > 17'(HUM_DEN)) ? HUM_DEN : RAMP_W'(humidity);

    if (cfg.mode == MODE_HUMID) begin
      rnum_nxt = h_num;
      rden_nxt = HUM_DEN;
    end else begin
      rnum_nxt = t_num;
      rden_nxt = TEMP_DEN;
    end
  end

  logic              e_neg_r;
  logic [MAXE_W-1:0] n_neg_r;
  logic [H_W-1:0]    h100_r;
  logic [RAMP_W-1:0] rnum_r;
  logic [RAMP_W-1:0] rden_r;
  logic [BC_W-1:0]   bc_r;
  logic [BI_W-1:0]   bi_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      e_neg_r <= elevation[ELEV_W-1];
      n_neg_r <= n_neg_nxt;
      h100_r  <= h100_nxt;
      rnum_r  <= rnum_nxt;
      rden_r  <= rden_nxt;
      bc_r    <= biome_color;
      bi_r    <= biome_index;
    end
  end

  // ---------------- stage 2: pick band and channel operands
  logic [H_W-1:0] m8, m45, m78, m37, m33, m22;
  assign m8  = H_W'(m_eff) * H_W'(8);
  assign m45 = H_W'(m_eff) * H_W'(45);
  assign m78 = H_W'(m_eff) * H_W'(78);
  assign m37 = H_W'(m_eff) * H_W'(37);
  assign m33 = H_W'(m_eff) * H_W'(33);
  assign m22 = H_W'(m_eff) * H_W'(22);

  logic [RAMP_W:0]   twice;
  logic [RAMP_W:0]   den_x;
  logic [RAMP_W-1:0] dn;
  logic [RAMP_W:0]   dn2;
  logic [RAMP_W:0]   dev;
  logic [RAMP_W-1:0] nr, ng, nb;

  chan_op_t [2:0]   ops_nxt;
  logic [NUM_W-1:0] den_nxt;
  rgb_t             pal;

  function automatic chan_op_t mk_op(input logic [CH_W-1:0] base, input logic neg,
                                     input logic [CH_W-1:0] k,
                                     input logic [NUM_W-1:0] num);
    chan_op_t o;
    o.base = base;
    o.neg  = neg;
    o.k    = k;
    o.num  = num;
    return o;
  endfunction

  always_comb begin
    // Blue-red ramp numerators
    twice = {rnum_r, 1'b0};
    den_x = {1'b0, rden_r};
    dn    = rden_r - rnum_r;
    dn2   = {dn, 1'b0};
    nr    = (twice >= den_x) ? rden_r : twice[RAMP_W-1:0];
    nb    = (dn2 >= den_x) ? rden_r : dn2[RAMP_W-1:0];
    dev   = (twice >= den_x) ? (twice - den_x) : (den_x - twice);
    ng    = rden_r - dev[RAMP_W-1:0];

    pal     = palette(3'(cfg.level));
    ops_nxt = '0;
    den_nxt = NUM_W'(1);

    case (cfg.mode)
      MODE_BIOME: begin
        ops_nxt[0] = mk_op(bc_r[23:16], 1'b0, '0, '0);
        ops_nxt[1] = mk_op(bc_r[15:8],  1'b0, '0, '0);
        ops_nxt[2] = mk_op(bc_r[7:0],   1'b0, '0, '0);
      end
      MODE_LEVEL, MODE_FACE, MODE_BIOME_IDX: begin
        if (cfg.mode == MODE_FACE) begin
          pal = palette(cfg.face);
        end else if (cfg.mode == MODE_BIOME_IDX) begin
          pal = palette(bi_r[2:0]);
        end
        ops_nxt[0] = mk_op(pal.r, 1'b0, '0, '0);
        ops_nxt[1] = mk_op(pal.g, 1'b0, '0, '0);
        ops_nxt[2] = mk_op(pal.b, 1'b0, '0, '0);
      end
      MODE_ELEV: begin
        if (e_neg_r) begin
          den_nxt    = NUM_W'(d_eff);
          ops_nxt[0] = mk_op(8'd40,  1'b1, 8'd35,  NUM_W'(n_neg_r));
          ops_nxt[1] = mk_op(8'd90,  1'b1, 8'd65,  NUM_W'(n_neg_r));
          ops_nxt[2] = mk_op(8'd180, 1'b1, 8'd120, NUM_W'(n_neg_r));
        end else if (h100_r < m8) begin
          ops_nxt[0] = mk_op(8'd210, 1'b0, '0, '0);
          ops_nxt[1] = mk_op(8'd200, 1'b0, '0, '0);
          ops_nxt[2] = mk_op(8'd150, 1'b0, '0, '0);
        end else if (h100_r < m45) begin
          den_nxt    = NUM_W'(m37);
          ops_nxt[0] = mk_op(8'd70,  1'b0, 8'd50, NUM_W'(h100_r - m8));
          ops_nxt[1] = mk_op(8'd140, 1'b1, 8'd30, NUM_W'(h100_r - m8));
          ops_nxt[2] = mk_op(8'd60,  1'b0, 8'd0,  NUM_W'(h100_r - m8));
        end else if (h100_r < m78) begin
          den_nxt    = NUM_W'(m33);
          ops_nxt[0] = mk_op(8'd120, 1'b0, 8'd30, NUM_W'(h100_r - m45));
          ops_nxt[1] = mk_op(8'd110, 1'b0, 8'd20, NUM_W'(h100_r - m45));
          ops_nxt[2] = mk_op(8'd60,  1'b0, 8'd60, NUM_W'(h100_r - m45));
        end else begin
          den_nxt    = NUM_W'(m22);
          ops_nxt[0] = mk_op(8'd180, 1'b0, 8'd75, NUM_W'(h100_r - m78));
          ops_nxt[1] = mk_op(8'd180, 1'b0, 8'd75, NUM_W'(h100_r - m78));
          ops_nxt[2] = mk_op(8'd180, 1'b0, 8'd75, NUM_W'(h100_r - m78));
        end
      end
      MODE_TEMP, MODE_HUMID: begin
        den_nxt    = NUM_W'(rden_r);
        ops_nxt[0] = mk_op(8'd0, 1'b0, 8'd255, NUM_W'(nr));
        ops_nxt[1] = mk_op(8'd0, 1'b0, 8'd200, NUM_W'(ng));
        ops_nxt[2] = mk_op(8'd0, 1'b0, 8'd255, NUM_W'(nb));
      end
      default: begin
        // checker colors are chosen at the output stage
        ops_nxt = '0;
      end
    endcase
  end

  chan_op_t [2:0]   ops_r;
  logic [NUM_W-1:0] den_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      ops_r <= ops_nxt;
      den_r <= den_nxt;
    end
  end

  assign ops = ops_r;
  assign den = den_r;

endmodule

// ===== rtl/vdfc_div.sv =====
// One color channel: multiply stage, then a restoring divider that settles
// one quotient bit per register stage. Depends on vdfc_pkg.
module vdfc_div import vdfc_pkg::*; (
  input  logic             clk,
  input  logic             pipe_en,
  input  chan_op_t         op,
  input  logic [NUM_W-1:0] den,
  output div_res_t         res
);

  logic [PROD_W-1:0] rem_r  [0:Q_W];
  logic [NUM_W-1:0]  den_r  [0:Q_W];
  logic [Q_W-1:0]    q_r    [0:Q_W];
  logic [CH_W-1:0]   base_r [0:Q_W];
  logic              neg_r  [0:Q_W];

  // Form the dividend k * num
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      rem_r[0]  <= PROD_W'(op.k) * PROD_W'(op.num);
      den_r[0]  <= den;
      q_r[0]    <= '0;
      base_r[0] <= op.base;
      neg_r[0]  <= op.neg;
    end
  end

  // Quotient bit Q_W-s in stage s
  for (genvar s = 1; s <= Q_W; s++) begin : g_step
    logic [PROD_W-1:0] shifted;
    logic              ge;
    assign shifted = PROD_W'(den_r[s-1]) << (Q_W - s);
    assign ge      = rem_r[s-1] >= shifted;

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        rem_r[s]  <= ge ? (rem_r[s-1] - shifted) : rem_r[s-1];
        den_r[s]  <= den_r[s-1];
        q_r[s]    <= {q_r[s-1][Q_W-2:0], ge};
        base_r[s] <= base_r[s-1];
        neg_r[s]  <= neg_r[s-1];
      end
    end
  end

  assign res.base   = base_r[Q_W];
  assign res.neg    = neg_r[Q_W];
  assign res.q      = q_r[Q_W];
  assign res.rem_nz = |rem_r[Q_W];

endmodule

// ===== rtl/vdfc_chk.sv =====
// Checkerboard outline detection: vertex_index modulo the grid width in a
// two-bits-per-stage remainder pipeline, aligned to the color path. Uses vdfc_pkg.
module vdfc_chk import vdfc_pkg::*; #(
  parameter int unsigned GRID_RES_MAX = GRID_RES_MAX_DEF
) (
  input  logic              clk,
  input  logic              pipe_en,
  input  logic [GRID_W-1:0] grid_res,
  input  logic [VI_W-1:0]   vertex_index,
  output logic              edge_flag
);

  // Saturated grid width; user must keep stable while transactions are in flight
  logic [GRID_W-1:0]   r_eff;
  logic [2*GRID_W-1:0] rr;
  logic [2*GRID_W-1:0] r_last_row;
  logic                row_edge;
  logic                r_zero;

  assign r_eff      = (32'(grid_res) > GRID_RES_MAX) ? GRID_W'(GRID_RES_MAX) : grid_res;
  assign rr         = (2*GRID_W)'(r_eff) * (2*GRID_W)'(r_eff);
  assign r_last_row = rr - (2*GRID_W)'(r_eff);
  assign r_zero     = (r_eff == '0);
  assign row_edge   = ((2*GRID_W)'(vertex_index) < (2*GRID_W)'(r_eff)) ||
                      (((2*GRID_W)'(vertex_index) >= r_last_row) &&
                       ((2*GRID_W)'(vertex_index) < rr));

  logic [VI_W-1:0]   vi_r   [0:CHK_STAGES];
  logic [GRID_W:0]   rem_r  [0:CHK_STAGES];
  logic              flag_r [0:CHK_STAGES];

  // Capture index and row-based edge
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      vi_r[0]   <= vertex_index;
      rem_r[0]  <= '0;
      flag_r[0] <= r_zero || row_edge;
    end
  end

  // Shift in index bits, reducing modulo the grid width
  for (genvar s = 1; s <= CHK_STAGES; s++) begin : g_mod
    logic [GRID_W:0] rem_nxt;
    always_comb begin
      logic [GRID_W+1:0] acc;
      acc     = '0;
      rem_nxt = rem_r[s-1];
      for (int b = 0; b < CHK_BITS_PER_STAGE; b++) begin
        acc     = {rem_nxt, vi_r[s-1][VI_W-1-b]};
        if (acc >= (GRID_W+2)'(r_eff)) begin
          acc = acc - (GRID_W+2)'(r_eff);
        end
        rem_nxt = acc[GRID_W:0];
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        vi_r[s]   <= vi_r[s-1] << CHK_BITS_PER_STAGE;
        rem_r[s]  <= rem_nxt;
        flag_r[s] <= flag_r[s-1];
      end
    end
  end

  // Column edge test, then pad to the color path latency
  localparam int unsigned PAD = PIPE_LAT - CHK_STAGES - 1;
  logic [PAD-1:0] edge_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      edge_r[0] <= flag_r[CHK_STAGES] ||
                   (rem_r[CHK_STAGES] == '0) ||
                   (rem_r[CHK_STAGES] == (GRID_W+1)'(r_eff) - (GRID_W+1)'(1));
      for (int i = 1; i < PAD; i++) begin
        edge_r[i] <= edge_r[i-1];
      end
    end
  end

  assign edge_flag = edge_r[PAD-1];

endmodule

// ===== rtl/vertex_debug_false_color_unit.sv =====
// Top level of the per-vertex false-color encoder: register file, valid
// pipeline and output stage. Depends on vdfc_pkg, vdfc_prep, vdfc_div, vdfc_chk.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_stall    vertex fields
//   out_     output     out_valid / out_stall  red, green, blue
//   cfg      input      psel/penable/pready    8 registers, 4-byte stride
//
// One transaction per cycle unless out_stall holds the pipeline. The path is two
// operand stages, a multiply stage, eight restoring-divide stages (one quotient bit
// each) and the output register. Reset is synchronous and clears valid bits and the
// configuration registers. out_stall holds the whole pipeline, including the output
// register, while a result waits; in_stall is raised only then.
`include "assert_macros.svh"
module vertex_debug_false_color_unit import vdfc_pkg::*; #(
  parameter int unsigned GRID_RESOLUTION_MAX = GRID_RES_MAX_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [VI_W-1:0]          in_vertex_index,
  input  logic signed [ELEV_W-1:0] in_elevation,
  input  logic [BC_W-1:0]          in_biome_color,
  input  logic [BI_W-1:0]          in_biome_index,
  input  logic [TEMP_W-1:0]        in_temperature,
  input  logic [HUM_W-1:0]         in_humidity,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [CH_W-1:0]          out_red,
  output logic [CH_W-1:0]          out_green,
  output logic [CH_W-1:0]          out_blue,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [4:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  // ---------------- configuration registers
  cfg_t     cfg_r;
  reg_idx_t widx;
  logic     cfg_wr;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[4:2]);
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode      <= MODE_BIOME;
      cfg_r.max_elev  <= MIN_SPAN;
      cfg_r.max_depth <= MIN_SPAN;
      cfg_r.grid_res  <= '0;
      cfg_r.level     <= '0;
      cfg_r.face      <= '0;
      cfg_r.px        <= '0;
      cfg_r.py        <= '0;
    end else if (cfg_wr) begin
      case (widx)
        REG_COLOR_MODE:  cfg_r.mode      <= mode_t'(pwdata[2:0]);
        REG_MAX_ELEV:    cfg_r.max_elev  <= pwdata[MAXE_W-1:0];
        REG_MAX_DEPTH:   cfg_r.max_depth <= pwdata[MAXE_W-1:0];
        REG_GRID_RES:    cfg_r.grid_res  <= pwdata[GRID_W-1:0];
        REG_PATCH_LEVEL: cfg_r.level     <= pwdata[LEVEL_W-1:0];
        REG_PATCH_FACE:  cfg_r.face      <= pwdata[FACE_W-1:0];
        REG_PATCH_X:     cfg_r.px        <= pwdata[PATCH_W-1:0];
        REG_PATCH_Y:     cfg_r.py        <= pwdata[PATCH_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (widx)
      REG_COLOR_MODE:  prdata = 32'(cfg_r.mode);
      REG_MAX_ELEV:    prdata = 32'(cfg_r.max_elev);
      REG_MAX_DEPTH:   prdata = 32'(cfg_r.max_depth);
      REG_GRID_RES:    prdata = 32'(cfg_r.grid_res);
      REG_PATCH_LEVEL: prdata = 32'(cfg_r.level);
      REG_PATCH_FACE:  prdata = 32'(cfg_r.face);
      REG_PATCH_X:     prdata = 32'(cfg_r.px);
      REG_PATCH_Y:     prdata = 32'(cfg_r.py);
      default:         prdata = '0;
    endcase
  end

  // ---------------- pipeline control
  logic                pipe_en;
  logic                accept;
  logic [PIPE_LAT-1:0] v_r;
  logic                out_valid_r;

  assign pipe_en  = !out_valid_r || !out_stall;
  assign in_stall = !pipe_en;
  assign accept   = in_valid && !in_stall;

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      v_r         <= {v_r[PIPE_LAT-2:0], accept};
      out_valid_r <= v_r[PIPE_LAT-1];
    end
  end

  // ---------------- datapath
  chan_op_t [2:0]   ops;
  logic [NUM_W-1:0] den;
  div_res_t [2:0]   dres;
  logic             edge_flag;

  vdfc_prep u_prep (
    .clk         (clk),
    .pipe_en     (pipe_en),
    .cfg         (cfg_r),
    .elevation   (in_elevation),
    .biome_color (in_biome_color),
    .biome_index (in_biome_index),
    .temperature (in_temperature),
    .humidity    (in_humidity),
    .ops         (ops),
    .den         (den)
  );

  for (genvar c = 0; c < 3; c++) begin : g_chan
    vdfc_div u_div (
      .clk     (clk),
      .pipe_en (pipe_en),
      .op      (ops[c]),
      .den     (den),
      .res     (dres[c])
    );
  end

  vdfc_chk #(
    .GRID_RES_MAX (GRID_RESOLUTION_MAX)
  ) u_chk (
    .clk          (clk),
    .pipe_en      (pipe_en),
    .grid_res     (cfg_r.grid_res),
    .vertex_index (in_vertex_index),
    .edge_flag    (edge_flag)
  );

  // ---------------- output stage: apply floor or ceiling, pick checker
  logic [CH_W-1:0] chan [0:2];
  rgb_t            color_nxt;
  rgb_t            color_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (dres[c].neg) begin
        chan[c] = dres[c].base - dres[c].q - CH_W'(dres[c].rem_nz);
      end else begin
        chan[c] = dres[c].base + dres[c].q;
      end
    end
    if (cfg_r.mode == MODE_CHECKER) begin
      if (edge_flag) begin
        color_nxt = '{r: 8'd255, g: 8'd255, b: 8'd0};
      end else if (cfg_r.px[0] ^ cfg_r.py[0]) begin
        color_nxt = '{r: 8'd90, g: 8'd90, b: 8'd110};
      end else begin
        color_nxt = '{r: 8'd160, g: 8'd160, b: 8'd180};
      end
    end else begin
      color_nxt = '{r: chan[0], g: chan[1], b: chan[2]};
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      color_r <= color_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = color_r.r;
  assign out_green = color_r.g;
  assign out_blue  = color_r.b;

  // ---------------- assertions
  `VDFC_ASSERT_NEXT(a_accept_enters, accept, v_r[0], "accepted transaction not in pipeline")
  `VDFC_ASSERT_NEXT(a_hold_on_stall, !pipe_en, v_r == $past(v_r), "valid bits moved during stall")
  `VDFC_ASSERT_NEXT(a_last_to_out, v_r[PIPE_LAT-1] && pipe_en, out_valid_r, "result lost at output")

endmodule

// ===== test/tb_vertex_debug_false_color_unit.sv =====
// Self-checking testbench for the vertex false-color encoder.
// It depends on vdfc_pkg and the vertex_debug_false_color_unit RTL. Directed rows,
// then random vertices, are checked against an in-bench color predictor.
`timescale 1ns / 100ps
module tb_vertex_debug_false_color_unit;
  import vdfc_pkg::*;

  localparam int unsigned RES_MAX   = 256;
  localparam int unsigned LATENCY   = 12;
  localparam int unsigned CYCLE_CAP = 400000;
  localparam int unsigned N_RANDOM  = 600;

  typedef struct {
    logic [VI_W-1:0]          vi;
    logic signed [ELEV_W-1:0] elev;
    logic [BC_W-1:0]          bc;
    logic [BI_W-1:0]          bi;
    logic [TEMP_W-1:0]        temp;
    logic [HUM_W-1:0]         hum;
  } vertex_t;

  typedef struct {
    int      cfg_sel;
    vertex_t v;
    bit      known;
    rgb_t    color;
  } vec_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [VI_W-1:0]          in_vertex_index;
  logic signed [ELEV_W-1:0] in_elevation;
  logic [BC_W-1:0]          in_biome_color;
  logic [BI_W-1:0]          in_biome_index;
  logic [TEMP_W-1:0]        in_temperature;
  logic [HUM_W-1:0]         in_humidity;
  logic                     out_valid;
  logic                     out_stall;
  logic [CH_W-1:0]          out_red;
  logic [CH_W-1:0]          out_green;
  logic [CH_W-1:0]          out_blue;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [4:0]               paddr;
  logic [31:0]              pwdata;
  logic [31:0]              prdata;
  logic                     pready;

  cfg_t        cur_cfg;
  rgb_t        color_q[$];
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;

  vertex_debug_false_color_unit #(.GRID_RESOLUTION_MAX(RES_MAX)) DUT (.*);

  // Free-running clock, 20 ns period
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // floor(a + (b - a) * num / den), clipped at zero
  function automatic longint color_lerp(longint a, longint b, longint num, longint den);
    longint v;
    v = a * den + (b - a) * num;
    if (v < 0) v = 0;
    return v / den;
  endfunction

  // Blue-red ramp for num / den clamped to [0,1]
  function automatic rgb_t blue_red_ramp(longint num, longint den);
    rgb_t   c;
    longint dev;
    if (num < 0) num = 0;
    if (num > den) num = den;
    c.r = (2 * num >= den) ? 8'd255 : CH_W'((2 * num * 255) / den);
    c.b = (2 * (den - num) >= den) ? 8'd255 : CH_W'((2 * (den - num) * 255) / den);
    dev = 2 * num - den;
    if (dev < 0) dev = -dev;
    c.g = CH_W'(((den - dev) * 200) / den);
    return c;
  endfunction

  function automatic rgb_t elevation_ramp(cfg_t c, longint e);
    rgb_t   o;
    longint m, d, n, h, tn, td, w;
    m = (c.max_elev < 16) ? 16 : longint'(c.max_elev);
    d = (c.max_depth < 16) ? 16 : longint'(c.max_depth);
    if (e < 0) begin
      n = (-e > d) ? d : -e;
      o.r = CH_W'(color_lerp(40, 5, n, d));
      o.g = CH_W'(color_lerp(90, 25, n, d));
      o.b = CH_W'(color_lerp(180, 60, n, d));
      return o;
    end
    n = (e > m) ? m : e;
    h = 100 * n;
    if (h < 8 * m) begin
      o = '{r: 8'd210, g: 8'd200, b: 8'd150};
    end else if (h < 45 * m) begin
      tn = h - 8 * m;
      td = 37 * m;
      o.r = CH_W'(color_lerp(70, 120, tn, td));
      o.g = CH_W'(color_lerp(140, 110, tn, td));
      o.b = CH_W'(color_lerp(60, 60, tn, td));
    end else if (h < 78 * m) begin
      tn = h - 45 * m;
      td = 33 * m;
      o.r = CH_W'(color_lerp(120, 150, tn, td));
      o.g = CH_W'(color_lerp(110, 130, tn, td));
      o.b = CH_W'(color_lerp(60, 120, tn, td));
    end else begin
      w = color_lerp(180, 255, h - 78 * m, 22 * m);
      o = '{r: CH_W'(w), g: CH_W'(w), b: CH_W'(w)};
    end
    return o;
  endfunction

  function automatic rgb_t checker_color(cfg_t c, longint vi);
    longint r, row, col;
    bit     border;
    r = (c.grid_res > RES_MAX) ? RES_MAX : longint'(c.grid_res);
    if (r == 0) begin
      border = 1'b1;
    end else begin
      row = vi / r;
      col = vi % r;
      border = (row == 0) || (col == 0) || (row == r - 1) || (col == r - 1);
    end
    if (border) return '{r: 8'd255, g: 8'd255, b: 8'd0};
    if (((c.px + c.py) & 1) != 0) return '{r: 8'd90, g: 8'd90, b: 8'd110};
    return '{r: 8'd160, g: 8'd160, b: 8'd180};
  endfunction

  function automatic rgb_t palette_color(logic [2:0] idx);
    case (idx)
      3'd0:    return '{r: 8'd220, g: 8'd60,  b: 8'd60};
      3'd1:    return '{r: 8'd60,  g: 8'd200, b: 8'd90};
      3'd2:    return '{r: 8'd70,  g: 8'd110, b: 8'd230};
      3'd3:    return '{r: 8'd230, g: 8'd190, b: 8'd60};
      3'd4:    return '{r: 8'd200, g: 8'd90,  b: 8'd220};
      3'd5:    return '{r: 8'd70,  g: 8'd210, b: 8'd210};
      3'd6:    return '{r: 8'd240, g: 8'd140, b: 8'd60};
      default: return '{r: 8'd170, g: 8'd170, b: 8'd170};
    endcase
  endfunction

  function automatic rgb_t predict_color(cfg_t c, vertex_t v);
    case (c.mode)
      MODE_LEVEL:     return palette_color(c.level[2:0]);
      MODE_FACE:      return palette_color(c.face);
      MODE_CHECKER:   return checker_color(c, longint'(v.vi));
      MODE_ELEV:      return elevation_ramp(c, longint'(v.elev));
      MODE_TEMP:      return blue_red_ramp(100 * longint'(v.temp) - 5712640, 2560000);
      MODE_HUMID:     return blue_red_ramp(longint'(v.hum), 65536);
      MODE_BIOME_IDX: return palette_color(v.bi[2:0]);
      default:        return '{r: v.bc[23:16], g: v.bc[15:8], b: v.bc[7:0]};
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR t=%0t %s: got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  // Register write: setup cycle, then access cycle
  task automatic reg_write(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(idx) << 2;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_cfg(cfg_t c);
    reg_write(REG_COLOR_MODE, 32'(c.mode));
    reg_write(REG_MAX_ELEV, 32'(c.max_elev));
    reg_write(REG_MAX_DEPTH, 32'(c.max_depth));
    reg_write(REG_GRID_RES, 32'(c.grid_res));
    reg_write(REG_PATCH_LEVEL, 32'(c.level));
    reg_write(REG_PATCH_FACE, 32'(c.face));
    reg_write(REG_PATCH_X, 32'(c.px));
    reg_write(REG_PATCH_Y, 32'(c.py));
    cur_cfg = c;
  endtask

  // Drop valid and hold until every queued color has come back
  task automatic drain_colors();
    in_valid <= 1'b0;
    @(posedge clk);
    while (color_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // Present one vertex and hold it until accepted; optional gap afterwards
  task automatic send_vertex(vertex_t v, bit known, rgb_t want, int gap);
    in_valid        <= 1'b1;
    in_vertex_index <= v.vi;
    in_elevation    <= v.elev;
    in_biome_color  <= v.bc;
    in_biome_index  <= v.bi;
    in_temperature  <= v.temp;
    in_humidity     <= v.hum;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (known && predict_color(cur_cfg, v) != want) begin
      report_mismatch("predictor vs directed table", int'(predict_color(cur_cfg, v)),
                      int'(want));
    end
    color_q.push_back(known ? want : predict_color(cur_cfg, v));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.mode = mode_t'($urandom_range(0, 7));
    case ($urandom_range(0, 4))
      0:       c.max_elev = 23'($urandom_range(0, 16));
      1:       c.max_elev = 23'h7FFFFF;
      2:       c.max_elev = 23'($urandom_range(16, 4000));
      default: c.max_elev = 23'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0:       c.max_depth = 23'($urandom_range(0, 16));
      1:       c.max_depth = 23'h7FFFFF;
      2:       c.max_depth = 23'($urandom_range(16, 4000));
      default: c.max_depth = 23'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0:       c.grid_res = 9'($urandom);
      1:       c.grid_res = 9'($urandom_range(0, 3));
      default: c.grid_res = 9'($urandom_range(2, 40));
    endcase
    c.level = 5'($urandom);
    c.face  = 3'($urandom);
    c.px    = 20'($urandom);
    c.py    = 20'($urandom);
    return c;
  endfunction

  function automatic vertex_t random_vertex(cfg_t c);
    vertex_t v;
    int      r;
    longint  span;
    v.vi   = 16'($urandom);
    v.elev = 24'($urandom);
    v.bc   = 24'($urandom);
    v.bi   = 8'($urandom);
    v.temp = 17'($urandom);
    v.hum  = 17'($urandom);
    // Mostly keep values inside the interesting bands of the active mode
    if ($urandom_range(0, 3) != 0) begin
      r = (c.grid_res > RES_MAX) ? RES_MAX : int'(c.grid_res);
      v.vi   = 16'($urandom_range(0, r * r + r));
      span   = (c.max_elev < 16) ? 16 : longint'(c.max_elev);
      if ($urandom_range(0, 1) != 0) v.elev = 24'($urandom_range(0, 32'(span + span / 8)));
      else v.elev = -24'($urandom_range(0, 32'(((c.max_depth < 16) ? 16 : c.max_depth) + 4)));
      v.temp = 17'($urandom_range(56000, 84000));
      v.hum  = 17'($urandom_range(0, 66000));
    end
    return v;
  endfunction

  // Receiver stall pattern: phases of none, light and heavy back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      case ((cycle_count / 200) % 3)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Compare each accepted color against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (color_q.size() == 0) begin
        report_mismatch("queued colors at color transaction", 0, 1);
      end else begin
        if (out_red != color_q[0].r) report_mismatch("red", out_red, color_q[0].r);
        if (out_green != color_q[0].g) report_mismatch("green", out_green, color_q[0].g);
        if (out_blue != color_q[0].b) report_mismatch("blue", out_blue, color_q[0].b);
        void'(color_q.pop_front());
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    cfg_t     cfg_sets[6];
    vec_row_t rows[$];
    vertex_t  v;
    cfg_t     c;
    int       sel;
    int       gap;
    int       left;

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_vertex_index = '0;
    in_elevation    = '0;
    in_biome_color  = '0;
    in_biome_index  = '0;
    in_temperature  = '0;
    in_humidity     = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Set 0 is the reset state; others cover five modes and the register extremes
    cfg_sets[0] = '{mode: MODE_BIOME, max_elev: 16, max_depth: 16, grid_res: 0,
                    level: 0, face: 0, px: 0, py: 0};
    cfg_sets[1] = '{mode: MODE_LEVEL, max_elev: 16, max_depth: 16, grid_res: 0,
                    level: 5'd31, face: 0, px: 0, py: 0};
    cfg_sets[2] = '{mode: MODE_FACE, max_elev: 16, max_depth: 16, grid_res: 0,
                    level: 0, face: 3'd7, px: 0, py: 0};
    cfg_sets[3] = '{mode: MODE_CHECKER, max_elev: 16, max_depth: 16, grid_res: 9'd511,
                    level: 0, face: 0, px: 20'hFFFFF, py: 20'd0};
    cfg_sets[4] = '{mode: MODE_ELEV, max_elev: 23'h7FFFFF, max_depth: 23'd0, grid_res: 0,
                    level: 0, face: 0, px: 0, py: 0};
    cfg_sets[5] = '{mode: MODE_HUMID, max_elev: 16, max_depth: 16, grid_res: 0,
                    level: 0, face: 0, px: 0, py: 0};

    // Directed rows: config set, vertex, expected color where obvious
    rows.push_back('{0, '{16'hFFFF, 24'sh7FFFFF, 24'hFFFFFF, 8'hFF, 17'h1FFFF, 17'h1FFFF},
                     1, '{8'hFF, 8'hFF, 8'hFF}});
    rows.push_back('{0, '{16'h0, -24'sd8388608, 24'h123456, 8'h0, 17'h0, 17'h0},
                     1, '{8'h12, 8'h34, 8'h56}});
    rows.push_back('{1, '{16'h0, 24'sd0, 24'h0, 8'h0, 17'h0, 17'h0},
                     1, '{8'd170, 8'd170, 8'd170}});
    rows.push_back('{2, '{16'h0, 24'sd0, 24'h0, 8'h0, 17'h0, 17'h0},
                     1, '{8'd170, 8'd170, 8'd170}});
    rows.push_back('{3, '{16'd0, 24'sd0, 24'h0, 8'h0, 17'h0, 17'h0},
                     1, '{8'd255, 8'd255, 8'd0}});
    rows.push_back('{3, '{16'd257, 24'sd0, 24'h0, 8'h0, 17'h0, 17'h0},
                     1, '{8'd90, 8'd90, 8'd110}});
    rows.push_back('{3, '{16'hFFFF, 24'sd0, 24'h0, 8'h0, 17'h0, 17'h0}, 0, '0});
    rows.push_back('{4, '{16'd0, -24'sd8388608, 24'h0, 8'h0, 17'h0, 17'h0},
                     1, '{8'd5, 8'd25, 8'd60}});
    rows.push_back('{4, '{16'd0, 24'sh7FFFFF, 24'h0, 8'h0, 17'h0, 17'h0},
                     1, '{8'd255, 8'd255, 8'd255}});
    rows.push_back('{4, '{16'd0, 24'sd0, 24'h0, 8'h0, 17'h0, 17'h0},
                     1, '{8'd210, 8'd200, 8'd150}});
    rows.push_back('{4, '{16'd0, 24'sd3000000, 24'h0, 8'h0, 17'h0, 17'h0}, 0, '0});
    rows.push_back('{4, '{16'd0, 24'sd5000000, 24'h0, 8'h0, 17'h0, 17'h0}, 0, '0});
    rows.push_back('{4, '{16'd0, 24'sd7000000, 24'h0, 8'h0, 17'h0, 17'h0}, 0, '0});
    rows.push_back('{4, '{16'd0, -24'sd7, 24'h0, 8'h0, 17'h0, 17'h0}, 0, '0});
    rows.push_back('{5, '{16'd0, 24'sd0, 24'h0, 8'h0, 17'h0, 17'd0},
                     1, '{8'd0, 8'd0, 8'd255}});
    rows.push_back('{5, '{16'd0, 24'sd0, 24'h0, 8'h0, 17'h0, 17'd32768},
                     1, '{8'd255, 8'd200, 8'd255}});
    rows.push_back('{5, '{16'd0, 24'sd0, 24'h0, 8'h0, 17'h0, 17'h1FFFF},
                     1, '{8'd255, 8'd0, 8'd0}});
    rows.push_back('{5, '{16'd0, 24'sd0, 24'h0, 8'h0, 17'h0, 17'd20000}, 0, '0});

    // Walk the directed table, reloading registers only when the set changes
    sel = 0;
    cur_cfg = cfg_sets[0];
    foreach (rows[i]) begin
      if (rows[i].cfg_sel != sel) begin
        drain_colors();
        sel = rows[i].cfg_sel;
        load_cfg(cfg_sets[sel]);
        @(posedge clk);
      end
      send_vertex(rows[i].v, rows[i].known, rows[i].color, 0);
    end

    // Temperature and biome index extremes, then random phases
    drain_colors();
    c = cfg_sets[0];
    c.mode = MODE_TEMP;
    load_cfg(c);
    @(posedge clk);
    v = '{16'd0, 24'sd0, 24'h0, 8'h0, 17'd0, 17'd0};
    send_vertex(v, 1, '{8'd0, 8'd0, 8'd255}, 0);
    v.temp = 17'h1FFFF;
    send_vertex(v, 1, '{8'd255, 8'd0, 8'd0}, 0);
    v.temp = 17'd69926;
    send_vertex(v, 0, '0, 0);
    drain_colors();
    c.mode = MODE_BIOME_IDX;
    load_cfg(c);
    @(posedge clk);
    v.bi = 8'hFF;
    send_vertex(v, 1, '{8'd170, 8'd170, 8'd170}, 0);

    left = N_RANDOM;
    while (left > 0) begin
      drain_colors();
      load_cfg(random_cfg());
      @(posedge clk);
      for (int k = 0; k < 60 && left > 0; k++) begin
        // Bursts: mostly back-to-back, occasionally a random gap
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : 0;
        if (k == 30 && left < N_RANDOM / 2 && left > N_RANDOM / 2 - 60) begin
          send_vertex(random_vertex(cur_cfg), 0, '0, 0);
          drain_colors();
          @(posedge clk);
        end else begin
          send_vertex(random_vertex(cur_cfg), 0, '0, gap);
        end
        left--;
      end
    end

    drain_colors();
    repeat (LATENCY) @(posedge clk);
    if (err_count == 0 && color_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
